[sv/scpa_pkg.sv]
// Shared types and constants of the strided padded correlate-accumulate block.
// Used by the register block, the controller, the datapath and the top level.
// Depends on nothing.
`default_nettype none

package scpa_pkg;

   typedef logic [2:0] opcode_type;

   localparam opcode_type OP_LOAD_INPUT  = 3'd0;
   localparam opcode_type OP_LOAD_KERNEL = 3'd1;
   localparam opcode_type OP_LOAD_OUTPUT = 3'd2;
   localparam opcode_type OP_RUN         = 3'd3;
   localparam opcode_type OP_READ_OUTPUT = 3'd4;

   localparam logic KIND_RUN  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam logic [2:0] REG_IN_WIDTH    = 3'd0;
   localparam logic [2:0] REG_IN_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_IN_DEPTH    = 3'd2;
   localparam logic [2:0] REG_KERN_WIDTH  = 3'd3;
   localparam logic [2:0] REG_KERN_HEIGHT = 3'd4;
   localparam logic [2:0] REG_PAD_AMOUNT  = 3'd5;
   localparam logic [2:0] REG_STEP_SIZE   = 3'd6;
   localparam logic [2:0] REG_OUT_DEPTH   = 3'd7;

   localparam logic [6:0] RESET_IN_WIDTH    = 7'd8;
   localparam logic [6:0] RESET_IN_HEIGHT   = 7'd8;
   localparam logic [4:0] RESET_IN_DEPTH    = 5'd1;
   localparam logic [4:0] RESET_KERN_WIDTH  = 5'd3;
   localparam logic [4:0] RESET_KERN_HEIGHT = 5'd3;
   localparam logic [3:0] RESET_PAD_AMOUNT  = 4'd0;
   localparam logic [4:0] RESET_STEP_SIZE   = 5'd1;
   localparam logic [4:0] RESET_OUT_DEPTH   = 5'd1;

   localparam logic [4:0] MAX_CHANNELS = 5'd16;
   localparam logic [4:0] MAX_KERNEL   = 5'd16;
   localparam logic [4:0] MAX_STEP     = 5'd16;

   typedef struct packed {
      opcode_type         opcode;
      logic        [11:0] word_index;
      logic signed [15:0] sample_value;
      logic signed [47:0] base_value;
   } req_word_type;

   typedef struct packed {
      logic               result_kind;
      logic               status_code;
      logic signed [47:0] read_value;
   } rsp_word_type;

   typedef struct packed {
      logic [6:0] in_width;
      logic [6:0] in_height;
      logic [4:0] in_depth;
      logic [4:0] kern_width;
      logic [4:0] kern_height;
      logic [3:0] pad_amount;
      logic [4:0] step_size;
      logic [4:0] out_depth;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic read;
      logic geo_load;
      logic geo_div;
      logic geo_area;
      logic geo_need;
      logic run_init;
      logic point_start;
      logic tap;
      logic point_write;
      logic clear_err;
   } cmd_type;

   typedef struct packed {
      logic range_ok;
      logic div_done;
      logic size_ok;
      logic tap_last;
      logic point_last;
      logic pipe_busy;
      logic err_flag;
      logic read_oob;
   } stat_type;

endpackage

`default_nettype wire

[sv/scpa_csr.sv]
// Configuration registers behind the APB-style port, with read back.
// Depends on scpa_pkg for the register layout, indexes and reset values.
`default_nettype none

module scpa_csr (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_psel,
   input  wire                  csr_penable,
   input  wire                  csr_pwrite,
   input  wire  [4:0]           csr_paddr,
   input  wire  [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output scpa_pkg::cfg_type    cfg
);

   scpa_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [2:0]        reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_width    <= scpa_pkg::RESET_IN_WIDTH;
         cfg_ff.in_height   <= scpa_pkg::RESET_IN_HEIGHT;
         cfg_ff.in_depth    <= scpa_pkg::RESET_IN_DEPTH;
         cfg_ff.kern_width  <= scpa_pkg::RESET_KERN_WIDTH;
         cfg_ff.kern_height <= scpa_pkg::RESET_KERN_HEIGHT;
         cfg_ff.pad_amount  <= scpa_pkg::RESET_PAD_AMOUNT;
         cfg_ff.step_size   <= scpa_pkg::RESET_STEP_SIZE;
         cfg_ff.out_depth   <= scpa_pkg::RESET_OUT_DEPTH;
      end else if (wr_en) begin
         unique case (reg_index)
            scpa_pkg::REG_IN_WIDTH:    cfg_ff.in_width    <= csr_pwdata[6:0];
            scpa_pkg::REG_IN_HEIGHT:   cfg_ff.in_height   <= csr_pwdata[6:0];
            scpa_pkg::REG_IN_DEPTH:    cfg_ff.in_depth    <= csr_pwdata[4:0];
            scpa_pkg::REG_KERN_WIDTH:  cfg_ff.kern_width  <= csr_pwdata[4:0];
            scpa_pkg::REG_KERN_HEIGHT: cfg_ff.kern_height <= csr_pwdata[4:0];
            scpa_pkg::REG_PAD_AMOUNT:  cfg_ff.pad_amount  <= csr_pwdata[3:0];
            scpa_pkg::REG_STEP_SIZE:   cfg_ff.step_size   <= csr_pwdata[4:0];
            scpa_pkg::REG_OUT_DEPTH:   cfg_ff.out_depth   <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         scpa_pkg::REG_IN_WIDTH:    csr_prdata = {25'd0, cfg_ff.in_width};
         scpa_pkg::REG_IN_HEIGHT:   csr_prdata = {25'd0, cfg_ff.in_height};
         scpa_pkg::REG_IN_DEPTH:    csr_prdata = {27'd0, cfg_ff.in_depth};
         scpa_pkg::REG_KERN_WIDTH:  csr_prdata = {27'd0, cfg_ff.kern_width};
         scpa_pkg::REG_KERN_HEIGHT: csr_prdata = {27'd0, cfg_ff.kern_height};
         scpa_pkg::REG_PAD_AMOUNT:  csr_prdata = {28'd0, cfg_ff.pad_amount};
         scpa_pkg::REG_STEP_SIZE:   csr_prdata = {27'd0, cfg_ff.step_size};
         scpa_pkg::REG_OUT_DEPTH:   csr_prdata = {27'd0, cfg_ff.out_depth};
         default:                   csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

[sv/scpa_datapath.sv]
// Datapath: the three stores, geometry checks, loop counters and the MAC pipeline.
// Depends on scpa_pkg; driven by commands from scpa_ctrl.
`default_nettype none

module scpa_datapath #(
   parameter int INPUT_WORDS  = 4096,
   parameter int KERNEL_WORDS = 1024,
   parameter int OUTPUT_WORDS = 4096,
   parameter int MAX_DIM      = 64
) (
   input  wire                         clock,
   input  wire                         reset,
   input  scpa_pkg::cfg_type           cfg,
   input  scpa_pkg::req_word_type      req_word,
   input  scpa_pkg::cmd_type           cmd,
   output scpa_pkg::stat_type          stat,
   output logic signed [47:0]          rd_data
);

   localparam int IN_AW  = $clog2(INPUT_WORDS);
   localparam int K_AW   = $clog2(KERNEL_WORDS);
   localparam int OUT_AW = $clog2(OUTPUT_WORDS);

   logic signed [15:0] in_mem  [INPUT_WORDS];
   logic signed [15:0] k_mem   [KERNEL_WORDS];
   logic signed [47:0] out_mem [OUTPUT_WORDS];

   logic in_idx_ok, k_idx_ok, out_idx_ok;
   logic wr_in, wr_k, wr_out_load;
   logic err_ff;

   assign in_idx_ok  = {20'd0, req_word.word_index} < 32'(INPUT_WORDS);
   assign k_idx_ok   = {20'd0, req_word.word_index} < 32'(KERNEL_WORDS);
   assign out_idx_ok = {20'd0, req_word.word_index} < 32'(OUTPUT_WORDS);

   assign wr_in       = cmd.load && req_word.opcode == scpa_pkg::OP_LOAD_INPUT && in_idx_ok;
   assign wr_k        = cmd.load && req_word.opcode == scpa_pkg::OP_LOAD_KERNEL && k_idx_ok;
   assign wr_out_load = cmd.load && req_word.opcode == scpa_pkg::OP_LOAD_OUTPUT && out_idx_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= 1'b0;
      end else if (cmd.clear_err) begin
         err_ff <= 1'b0;
      end else if (cmd.load && !wr_in && !wr_k && !wr_out_load) begin
         err_ff <= 1'b1;
      end
   end

   // Geometry.
   logic               range_ok;
   logic signed [9:0]  span_x, span_y;
   logic               geo_ok_ff;
   logic [8:0]         span_x_ff, span_y_ff, pos_x_ff, pos_y_ff;
   logic [9:0]         next_x, next_y;
   logic               adv_x, adv_y;
   logic [7:0]         out_w_ff, out_h_ff;
   logic [13:0]        in_area_ff;
   logic [9:0]         k_area_ff;
   logic [15:0]        o_area_ff;
   logic [18:0]        in_need_ff;
   logic [14:0]        k_need_ff;
   logic [20:0]        out_need_ff;

   assign range_ok = cfg.in_width != 7'd0 && {25'd0, cfg.in_width} <= 32'(MAX_DIM) &&
                     cfg.in_height != 7'd0 && {25'd0, cfg.in_height} <= 32'(MAX_DIM) &&
                     cfg.in_depth != 5'd0 && cfg.in_depth <= scpa_pkg::MAX_CHANNELS &&
                     cfg.kern_width != 5'd0 && cfg.kern_width <= scpa_pkg::MAX_KERNEL &&
                     cfg.kern_height != 5'd0 && cfg.kern_height <= scpa_pkg::MAX_KERNEL &&
                     cfg.step_size != 5'd0 && cfg.step_size <= scpa_pkg::MAX_STEP &&
                     cfg.out_depth != 5'd0 && cfg.out_depth <= scpa_pkg::MAX_CHANNELS;

   assign span_x = $signed({3'd0, cfg.in_width}) + $signed({5'd0, cfg.pad_amount, 1'b0})
                   - $signed({5'd0, cfg.kern_width});
   assign span_y = $signed({3'd0, cfg.in_height}) + $signed({5'd0, cfg.pad_amount, 1'b0})
                   - $signed({5'd0, cfg.kern_height});

   assign next_x = {1'b0, pos_x_ff} + {5'd0, cfg.step_size};
   assign next_y = {1'b0, pos_y_ff} + {5'd0, cfg.step_size};
   assign adv_x  = next_x <= {1'b0, span_x_ff};
   assign adv_y  = next_y <= {1'b0, span_y_ff};

   always_ff @(posedge clock) begin
      if (cmd.geo_load) begin
         geo_ok_ff  <= range_ok && !span_x[9] && !span_y[9];
         span_x_ff  <= span_x[8:0];
         span_y_ff  <= span_y[8:0];
         pos_x_ff   <= 9'd0;
         pos_y_ff   <= 9'd0;
         out_w_ff   <= 8'd1;
         out_h_ff   <= 8'd1;
         in_area_ff <= 14'(cfg.in_width) * 14'(cfg.in_height);
         k_area_ff  <= 10'(cfg.kern_width) * 10'(cfg.kern_height);
      end
      if (cmd.geo_div) begin
         if (adv_x) begin
            pos_x_ff <= next_x[8:0];
            out_w_ff <= out_w_ff + 8'd1;
         end
         if (adv_y) begin
            pos_y_ff <= next_y[8:0];
            out_h_ff <= out_h_ff + 8'd1;
         end
      end
      if (cmd.geo_area) begin
         o_area_ff  <= 16'(out_w_ff) * 16'(out_h_ff);
         in_need_ff <= 19'(cfg.in_depth) * 19'(in_area_ff);
         k_need_ff  <= 15'(cfg.in_depth) * 15'(k_area_ff);
      end
      if (cmd.geo_need) begin
         out_need_ff <= 21'(cfg.out_depth) * 21'(o_area_ff);
      end
   end

   // Loop counters.
   logic [3:0]        d_ff, kx_ff, ky_ff, c_ff;
   logic [7:0]        ox_ff, oy_ff;
   logic [OUT_AW-1:0] oi_ff;
   logic [3:0]        id_m1, kw_m1, kh_m1, od_m1;
   logic [7:0]        ow_m1, oh_m1;
   logic              tap_last, point_last;

   assign id_m1 = 4'(cfg.in_depth - 5'd1);
   assign kw_m1 = 4'(cfg.kern_width - 5'd1);
   assign kh_m1 = 4'(cfg.kern_height - 5'd1);
   assign od_m1 = 4'(cfg.out_depth - 5'd1);
   assign ow_m1 = out_w_ff - 8'd1;
   assign oh_m1 = out_h_ff - 8'd1;

   assign tap_last   = d_ff == id_m1 && kx_ff == kw_m1 && ky_ff == kh_m1;
   assign point_last = ox_ff == ow_m1 && oy_ff == oh_m1 && c_ff == od_m1;

   always_ff @(posedge clock) begin
      if (cmd.point_start) begin
         d_ff  <= 4'd0;
         kx_ff <= 4'd0;
         ky_ff <= 4'd0;
      end else if (cmd.tap) begin
         if (d_ff != id_m1) begin
            d_ff <= d_ff + 4'd1;
         end else begin
            d_ff <= 4'd0;
            if (kx_ff != kw_m1) begin
               kx_ff <= kx_ff + 4'd1;
            end else begin
               kx_ff <= 4'd0;
               ky_ff <= ky_ff + 4'd1;
            end
         end
      end
      if (cmd.run_init) begin
         ox_ff <= 8'd0;
         oy_ff <= 8'd0;
         c_ff  <= 4'd0;
         oi_ff <= '0;
      end else if (cmd.point_write) begin
         oi_ff <= oi_ff + OUT_AW'(1);
         if (ox_ff != ow_m1) begin
            ox_ff <= ox_ff + 8'd1;
         end else begin
            ox_ff <= 8'd0;
            if (oy_ff != oh_m1) begin
               oy_ff <= oy_ff + 8'd1;
            end else begin
               oy_ff <= 8'd0;
               c_ff  <= c_ff + 4'd1;
            end
         end
      end
   end

   // MAC pipeline: position, address, store read, multiply, accumulate.
   logic [12:0]        oy_st, ox_st;
   logic signed [13:0] y_calc, x_calc;
   logic               b_v_ff, c_v_ff, d_v_ff, e_v_ff;
   logic signed [13:0] b_y_ff, b_x_ff;
   logic [17:0]        b_di_ff;
   logic [13:0]        b_dk_ff;
   logic [8:0]         b_kyw_ff;
   logic [3:0]         b_kx_ff;
   logic               y_in, x_in;
   logic [13:0]        yw;
   logic [18:0]        ii_calc;
   logic [14:0]        ki_calc;
   logic [IN_AW-1:0]   c_ii_ff;
   logic [K_AW-1:0]    c_ki_ff;
   logic signed [15:0] d_pix_ff, d_tap_ff;
   logic signed [31:0] e_prod_ff;
   logic signed [43:0] acc_ff;

   assign oy_st  = 13'(oy_ff) * 13'(cfg.step_size);
   assign ox_st  = 13'(ox_ff) * 13'(cfg.step_size);
   assign y_calc = $signed({1'b0, oy_st}) + $signed({10'd0, ky_ff})
                   - $signed({10'd0, cfg.pad_amount});
   assign x_calc = $signed({1'b0, ox_st}) + $signed({10'd0, kx_ff})
                   - $signed({10'd0, cfg.pad_amount});

   assign y_in    = !b_y_ff[13] && b_y_ff[12:0] < {6'd0, cfg.in_height};
   assign x_in    = !b_x_ff[13] && b_x_ff[12:0] < {6'd0, cfg.in_width};
   assign yw      = {7'd0, b_y_ff[6:0]} * {7'd0, cfg.in_width};
   assign ii_calc = 19'(b_di_ff) + 19'(yw) + 19'(b_x_ff[6:0]);
   assign ki_calc = 15'(b_dk_ff) + 15'(b_kyw_ff) + 15'(b_kx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
      end else begin
         b_v_ff <= cmd.tap;
         c_v_ff <= b_v_ff && y_in && x_in;
         d_v_ff <= c_v_ff;
         e_v_ff <= d_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_y_ff    <= y_calc;
      b_x_ff    <= x_calc;
      b_di_ff   <= 18'(d_ff) * 18'(in_area_ff);
      b_dk_ff   <= 14'(d_ff) * 14'(k_area_ff);
      b_kyw_ff  <= 9'(ky_ff) * 9'(cfg.kern_width);
      b_kx_ff   <= kx_ff;
      c_ii_ff   <= IN_AW'(ii_calc);
      c_ki_ff   <= K_AW'(ki_calc);
      e_prod_ff <= d_pix_ff * d_tap_ff;
      if (cmd.point_start) begin
         acc_ff <= '0;
      end else if (e_v_ff) begin
         acc_ff <= acc_ff + 44'(e_prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_in) begin
         in_mem[IN_AW'(req_word.word_index)] <= req_word.sample_value;
      end
      d_pix_ff <= in_mem[c_ii_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_k) begin
         k_mem[K_AW'(req_word.word_index)] <= req_word.sample_value;
      end
      d_tap_ff <= k_mem[c_ki_ff];
   end

   // Output store: base loads and finished sums share the write port.
   logic signed [48:0] sum;
   logic signed [47:0] sat_sum;
   logic signed [47:0] rd_ff;

   assign sum = 49'(rd_ff) + 49'(acc_ff);

   always_comb begin
      priority if (sum[48] != sum[47]) begin
         sat_sum = sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         sat_sum = sum[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_out_load) begin
         out_mem[OUT_AW'(req_word.word_index)] <= req_word.base_value;
      end else if (cmd.point_write) begin
         out_mem[oi_ff] <= sat_sum;
      end
      if (cmd.read) begin
         rd_ff <= out_mem[OUT_AW'(req_word.word_index)];
      end else if (cmd.point_start) begin
         rd_ff <= out_mem[oi_ff];
      end
   end

   assign rd_data = rd_ff;

   assign stat.range_ok   = geo_ok_ff;
   assign stat.div_done   = !adv_x && !adv_y;
   assign stat.size_ok    = {13'd0, in_need_ff} <= 32'(INPUT_WORDS) &&
                            {17'd0, k_need_ff} <= 32'(KERNEL_WORDS) &&
                            {11'd0, out_need_ff} <= 32'(OUTPUT_WORDS);
   assign stat.tap_last   = tap_last;
   assign stat.point_last = point_last;
   assign stat.pipe_busy  = b_v_ff || c_v_ff || d_v_ff || e_v_ff;
   assign stat.err_flag   = err_ff;
   assign stat.read_oob   = !out_idx_ok;

endmodule

`default_nettype wire

[sv/scpa_ctrl.sv]
// Controller: sequences loads, reads, the geometry check and the run loops.
// Depends on scpa_pkg; commands scpa_datapath and registers the result strobe.
`default_nettype none

module scpa_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  scpa_pkg::opcode_type   opcode,
   input  scpa_pkg::stat_type     stat,
   output scpa_pkg::cmd_type      cmd,
   output logic                   busy,
   output logic                   rsp_strobe,
   output logic                   rsp_kind,
   output logic                   rsp_status
);

   typedef enum logic [3:0] {
      IDLE,
      G_RANGE,
      G_DIV,
      G_AREA,
      G_NEED,
      G_SIZE,
      PT_START,
      TAPS,
      DRAIN,
      PT_WRITE,
      RESPOND
   } state_type;

   state_type state_ff;
   logic      strobe_ff, kind_ff, status_ff;
   logic      accept, finish, finish_bad;

   assign busy       = state_ff != IDLE;
   assign accept     = start && state_ff == IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_status = status_ff;

   assign finish = (state_ff == G_RANGE && !stat.range_ok) ||
                   (state_ff == G_SIZE && !stat.size_ok) ||
                   (state_ff == PT_WRITE && stat.point_last);
   assign finish_bad = state_ff != PT_WRITE;

   always_comb begin
      cmd             = '0;
      cmd.load        = accept && (opcode == scpa_pkg::OP_LOAD_INPUT ||
                                   opcode == scpa_pkg::OP_LOAD_KERNEL ||
                                   opcode == scpa_pkg::OP_LOAD_OUTPUT);
      cmd.read        = accept && opcode == scpa_pkg::OP_READ_OUTPUT;
      cmd.geo_load    = accept && opcode == scpa_pkg::OP_RUN;
      cmd.geo_div     = state_ff == G_DIV;
      cmd.geo_area    = state_ff == G_AREA;
      cmd.geo_need    = state_ff == G_NEED;
      cmd.run_init    = state_ff == G_SIZE && stat.size_ok;
      cmd.point_start = state_ff == PT_START;
      cmd.tap         = state_ff == TAPS;
      cmd.point_write = state_ff == PT_WRITE;
      cmd.clear_err   = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         strobe_ff <= 1'b0;
         kind_ff   <= scpa_pkg::KIND_RUN;
         status_ff <= scpa_pkg::STATUS_OK;
      end else begin
         strobe_ff <= 1'b0;
         if (finish) begin
            strobe_ff <= 1'b1;
            kind_ff   <= scpa_pkg::KIND_RUN;
            status_ff <= (finish_bad || stat.err_flag) ? scpa_pkg::STATUS_ERR
                                                       : scpa_pkg::STATUS_OK;
            state_ff  <= RESPOND;
         end else begin
            unique case (state_ff)
               IDLE: begin
                  if (accept) begin
                     unique case (opcode)
                        scpa_pkg::OP_READ_OUTPUT: begin
                           strobe_ff <= 1'b1;
                           kind_ff   <= scpa_pkg::KIND_READ;
                           status_ff <= stat.read_oob ? scpa_pkg::STATUS_ERR
                                                      : scpa_pkg::STATUS_OK;
                           state_ff  <= RESPOND;
                        end
                        scpa_pkg::OP_RUN: state_ff <= G_RANGE;
                        default: ;
                     endcase
                  end
               end
               G_RANGE:  state_ff <= G_DIV;
               G_DIV: begin
                  if (stat.div_done) begin
                     state_ff <= G_AREA;
                  end
               end
               G_AREA:   state_ff <= G_NEED;
               G_NEED:   state_ff <= G_SIZE;
               G_SIZE:   state_ff <= PT_START;
               PT_START: state_ff <= TAPS;
               TAPS: begin
                  if (stat.tap_last) begin
                     state_ff <= DRAIN;
                  end
               end
               DRAIN: begin
                  if (!stat.pipe_busy) begin
                     state_ff <= PT_WRITE;
                  end
               end
               PT_WRITE: state_ff <= PT_START;
               RESPOND:  state_ff <= IDLE;
               default:  state_ff <= IDLE;
            endcase
         end
      end
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe held for more than one cycle.");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("Result strobe while the block is idle.");

   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode == scpa_pkg::OP_READ_OUTPUT)
         |=> (rsp_strobe && rsp_kind == scpa_pkg::KIND_READ))
      else $error("Accepted read word did not answer in the next cycle.");

   a_load_no_stall: assert property (@(posedge clock) disable iff (reset)
      (accept && (opcode == scpa_pkg::OP_LOAD_INPUT || opcode == scpa_pkg::OP_LOAD_KERNEL ||
                  opcode == scpa_pkg::OP_LOAD_OUTPUT)) |=> !busy)
      else $error("Load word made the block busy.");

endmodule

`default_nettype wire

[sv/strided_padded_correlate_accumulate.sv]
// Top level of the strided padded correlate-accumulate block.
// Depends on scpa_pkg, scpa_csr, scpa_datapath and scpa_ctrl.
//
//   Port group   Direction  Handshake                    Word
//   req_         in         start high while busy low    req_word (scpa_pkg::req_word_type)
//   rsp_         out        rsp_strobe, one cycle        rsp_word (scpa_pkg::rsp_word_type)
//   csr_         in/out     APB setup and access, ready  32-bit register data
//
// A load word leaves busy low, so loads stream one per cycle.
// A read word answers in the next cycle from the registered output store port.
// A run is paced by the single multiply-accumulate pipeline, which takes one tap
// per cycle within each output point.
// Synchronous reset restores the registers and clears the error flag; stores are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module strided_padded_correlate_accumulate #(
   parameter int INPUT_WORDS  = 4096,
   parameter int KERNEL_WORDS = 1024,
   parameter int OUTPUT_WORDS = 4096,
   parameter int MAX_DIM      = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  scpa_pkg::req_word_type       req_word,
   output logic                         rsp_strobe,
   output scpa_pkg::rsp_word_type       rsp_word,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [4:0]                   csr_paddr,
   input  wire  [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   scpa_pkg::cfg_type  cfg;
   scpa_pkg::cmd_type  cmd;
   scpa_pkg::stat_type stat;
   logic signed [47:0] rd_data;
   logic               rsp_kind, rsp_status;

   scpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   scpa_datapath #(
      .INPUT_WORDS  (INPUT_WORDS),
      .KERNEL_WORDS (KERNEL_WORDS),
      .OUTPUT_WORDS (OUTPUT_WORDS),
      .MAX_DIM      (MAX_DIM)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_word (req_word),
      .cmd      (cmd),
      .stat     (stat),
      .rd_data  (rd_data)
   );

   scpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .opcode     (req_word.opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_kind   (rsp_kind),
      .rsp_status (rsp_status)
   );

   assign rsp_word.result_kind = rsp_kind;
   assign rsp_word.status_code = rsp_status;
   assign rsp_word.read_value  = (rsp_kind == scpa_pkg::KIND_READ &&
                                  rsp_status == scpa_pkg::STATUS_OK) ? rd_data : 48'sd0;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench of the strided padded correlate-accumulate block.
// It predicts every result in a scoreboard class and drives words and registers
// through plain tasks. Depends on scpa_pkg and strided_padded_correlate_accumulate.
`timescale 1ns / 1ps

module tb_top;

   class scpa_scoreboard;
      scpa_pkg::cfg_type cfg;
      logic signed [15:0] pixel_mem[4096];
      logic signed [15:0] tap_mem[1024];
      logic signed [47:0] sum_mem[4096];
      bit load_error;
      scpa_pkg::rsp_word_type pending[$];
      int mismatches;
      int failures;

      function new();
         cfg = '{scpa_pkg::RESET_IN_WIDTH, scpa_pkg::RESET_IN_HEIGHT,
                 scpa_pkg::RESET_IN_DEPTH, scpa_pkg::RESET_KERN_WIDTH,
                 scpa_pkg::RESET_KERN_HEIGHT, scpa_pkg::RESET_PAD_AMOUNT,
                 scpa_pkg::RESET_STEP_SIZE, scpa_pkg::RESET_OUT_DEPTH};
         load_error = 0;
         mismatches = 0;
         failures = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            scpa_pkg::REG_IN_WIDTH: cfg.in_width = v[6:0];
            scpa_pkg::REG_IN_HEIGHT: cfg.in_height = v[6:0];
            scpa_pkg::REG_IN_DEPTH: cfg.in_depth = v[4:0];
            scpa_pkg::REG_KERN_WIDTH: cfg.kern_width = v[4:0];
            scpa_pkg::REG_KERN_HEIGHT: cfg.kern_height = v[4:0];
            scpa_pkg::REG_PAD_AMOUNT: cfg.pad_amount = v[3:0];
            scpa_pkg::REG_STEP_SIZE: cfg.step_size = v[4:0];
            default: cfg.out_depth = v[4:0];
         endcase
      endfunction

      function bit geometry(scpa_pkg::cfg_type g, output int ow, output int oh);
         int iw, ih, id, kw, kh, pad, st, od;
         iw = g.in_width; ih = g.in_height; id = g.in_depth; kw = g.kern_width;
         kh = g.kern_height; pad = g.pad_amount; st = g.step_size; od = g.out_depth;
         ow = 0;
         oh = 0;
         if (iw < 1 || iw > 64 || ih < 1 || ih > 64 || id < 1 || id > 16 || kw < 1 ||
             kw > 16 || kh < 1 || kh > 16 || st < 1 || st > 16 || od < 1 || od > 16)
            return 0;
         if (iw + 2 * pad < kw || ih + 2 * pad < kh) return 0;
         ow = (iw - kw + 2 * pad) / st + 1;
         oh = (ih - kh + 2 * pad) / st + 1;
         if (id * iw * ih > 4096 || id * kw * kh > 1024 || od * ow * oh > 4096) return 0;
         return 1;
      endfunction

      function bit correlate();
         int ow, oh, oi, y, x;
         longint acc, total;
         if (!geometry(cfg, ow, oh)) return 0;
         for (int c = 0; c < cfg.out_depth; c++)
            for (int oy = 0; oy < oh; oy++)
               for (int ox = 0; ox < ow; ox++) begin
                  acc = 0;
                  oi = c * ow * oh + oy * ow + ox;
                  for (int ky = 0; ky < cfg.kern_height; ky++) begin
                     y = oy * cfg.step_size - cfg.pad_amount + ky;
                     if (y < 0 || y >= cfg.in_height) continue;
                     for (int kx = 0; kx < cfg.kern_width; kx++) begin
                        x = ox * cfg.step_size - cfg.pad_amount + kx;
                        if (x < 0 || x >= cfg.in_width) continue;
                        for (int d = 0; d < cfg.in_depth; d++)
                           acc += longint'(pixel_mem[d * cfg.in_width * cfg.in_height +
                                                     y * cfg.in_width + x]) *
                                  longint'(tap_mem[d * cfg.kern_width * cfg.kern_height +
                                                   ky * cfg.kern_width + kx]);
                     end
                  end
                  total = longint'(sum_mem[oi]) + acc;
                  if (total > 64'sh7FFF_FFFF_FFFF) total = 64'sh7FFF_FFFF_FFFF;
                  if (total < -64'sh8000_0000_0000) total = -64'sh8000_0000_0000;
                  sum_mem[oi] = total[47:0];
               end
         return 1;
      endfunction

      function void note_input(scpa_pkg::req_word_type w);
         scpa_pkg::rsp_word_type r;
         case (w.opcode)
            scpa_pkg::OP_LOAD_INPUT: pixel_mem[w.word_index] = w.sample_value;
            scpa_pkg::OP_LOAD_KERNEL:
               if (w.word_index < 1024) tap_mem[w.word_index] = w.sample_value;
               else load_error = 1;
            scpa_pkg::OP_LOAD_OUTPUT: sum_mem[w.word_index] = w.base_value;
            scpa_pkg::OP_RUN: begin
               r.result_kind = scpa_pkg::KIND_RUN;
               r.status_code = (!correlate() || load_error) ? scpa_pkg::STATUS_ERR
                                                            : scpa_pkg::STATUS_OK;
               r.read_value = '0;
               load_error = 0;
               pending.push_back(r);
            end
            scpa_pkg::OP_READ_OUTPUT: begin
               r.result_kind = scpa_pkg::KIND_READ;
               r.status_code = scpa_pkg::STATUS_OK;
               r.read_value = sum_mem[w.word_index];
               pending.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check_result(scpa_pkg::rsp_word_type r);
         scpa_pkg::rsp_word_type e;
         if (pending.size() == 0) begin
            failures++;
            if (++mismatches <= 10) $display("Unexpected word %h", r);
            return;
         end
         e = pending.pop_front();
         if (r.result_kind !== e.result_kind || r.status_code !== e.status_code ||
             r.read_value !== e.read_value) begin
            failures++;
            if (++mismatches <= 10)
               $display("Mismatch: expected kind %b status %b value %h, got %b %b %h",
                        e.result_kind, e.status_code, e.read_value,
                        r.result_kind, r.status_code, r.read_value);
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 300000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   scpa_pkg::req_word_type req_word = '0;
   logic rsp_strobe;
   scpa_pkg::rsp_word_type rsp_word;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   scpa_scoreboard sb = new();
   int gap_pct = 0;
   int sent = 0;
   int stalled = 0;
   bit sum_written[4096];

   strided_padded_correlate_accumulate DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .csr_psel(csr_psel),
      .csr_penable(csr_penable), .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_word);
      if (reset || (start && !busy) || rsp_strobe) stalled <= 0;
      else stalled <= stalled + 1;
      if (stalled >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic scpa_pkg::cfg_type make_cfg(int iw, int ih, int id, int kw, int kh,
                                                  int pad, int st, int od);
      scpa_pkg::cfg_type g;
      g.in_width = 7'(iw);
      g.in_height = 7'(ih);
      g.in_depth = 5'(id);
      g.kern_width = 5'(kw);
      g.kern_height = 5'(kh);
      g.pad_amount = 4'(pad);
      g.step_size = 5'(st);
      g.out_depth = 5'(od);
      return g;
   endfunction

   task automatic send(scpa_pkg::req_word_type w);
      while ($urandom_range(99) < gap_pct) begin
         start = 0;
         @(negedge clock);
      end
      req_word = w;
      start = 1;
      #1;
      while (busy) begin
         @(negedge clock);
         #1;
      end
      sb.note_input(w);
      if (w.opcode == scpa_pkg::OP_LOAD_OUTPUT) sum_written[w.word_index] = 1;
      sent++;
      @(negedge clock);
   endtask

   task automatic send_op(scpa_pkg::opcode_type op, int idx, logic [15:0] sample,
                          logic [47:0] base);
      scpa_pkg::req_word_type w;
      w.opcode = op;
      w.word_index = 12'(idx);
      w.sample_value = sample;
      w.base_value = base;
      send(w);
   endtask

   task automatic wait_idle();
      start = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = v;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      sb.set_reg(idx, v);
   endtask

   task automatic apply_cfg(scpa_pkg::cfg_type g);
      csr_write(scpa_pkg::REG_IN_WIDTH, 32'(g.in_width));
      csr_write(scpa_pkg::REG_IN_HEIGHT, 32'(g.in_height));
      csr_write(scpa_pkg::REG_IN_DEPTH, 32'(g.in_depth));
      csr_write(scpa_pkg::REG_KERN_WIDTH, 32'(g.kern_width));
      csr_write(scpa_pkg::REG_KERN_HEIGHT, 32'(g.kern_height));
      csr_write(scpa_pkg::REG_PAD_AMOUNT, 32'(g.pad_amount));
      csr_write(scpa_pkg::REG_STEP_SIZE, 32'(g.step_size));
      csr_write(scpa_pkg::REG_OUT_DEPTH, 32'(g.out_depth));
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] rand_base();
      case ($urandom_range(9))
         0: return 48'h7FFF_FFFF_FF00 + 48'($urandom_range(255));
         1: return 48'h8000_0000_0000 + 48'($urandom_range(255));
         default: return 48'({$urandom, $urandom});
      endcase
   endfunction

   task automatic noise_item();
      int idx;
      case ($urandom_range(3))
         0: send_op(scpa_pkg::opcode_type'($urandom_range(5, 7)), $urandom_range(4095),
                    16'($urandom), rand_base());
         1: send_op(scpa_pkg::OP_LOAD_KERNEL, $urandom_range(1024, 4095), 16'($urandom),
                    rand_base());
         default: begin
            idx = $urandom_range(4095);
            if (sum_written[idx])
               send_op(scpa_pkg::OP_READ_OUTPUT, idx, 16'($urandom), rand_base());
         end
      endcase
   endtask

   task automatic random_phase(int phase);
      scpa_pkg::cfg_type g;
      int ow, oh, n_pix, n_tap, n_sum, kind;
      bit ok;
      wait_idle();
      gap_pct = (phase % 4 == 1) ? 67 : (phase % 4 == 3) ? 25 : 0;
      kind = $urandom_range(9);
      if (kind == 0) begin
         g = make_cfg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
         if ($urandom_range(1)) g.step_size = 5'd0;
         else g.in_width = 7'd127;
      end else if (kind == 1) begin
         case ($urandom_range(2))
            0: g = make_cfg(64, 1, 1, 16, 1, 15, 16, 1);
            1: g = make_cfg(1, 1, 16, 1, 1, 0, 1, 16);
            default: g = make_cfg(1, 64, 1, 1, 16, 15, 16, 1);
         endcase
      end else begin
         do begin
            g = make_cfg($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(1, 4),
                         $urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(0, 3),
                         $urandom_range(1, 4), $urandom_range(1, 3));
            ok = sb.geometry(g, ow, oh);
         end while (!ok || g.out_depth * ow * oh *
                    (g.kern_width * g.kern_height * g.in_depth + 7) > 12000);
      end
      apply_cfg(g);
      ok = sb.geometry(g, ow, oh);
      if (ok) begin
         n_pix = g.in_depth * g.in_width * g.in_height;
         n_tap = g.in_depth * g.kern_width * g.kern_height;
         n_sum = g.out_depth * ow * oh;
         for (int i = 0; i < n_pix; i++) begin
            if ($urandom_range(19) == 0) noise_item();
            send_op(scpa_pkg::OP_LOAD_INPUT, i, rand_sample(), rand_base());
         end
         for (int i = 0; i < n_tap; i++)
            send_op(scpa_pkg::OP_LOAD_KERNEL, i, rand_sample(), rand_base());
         for (int i = 0; i < n_sum; i++)
            send_op(scpa_pkg::OP_LOAD_OUTPUT, i, rand_sample(), rand_base());
         send_op(scpa_pkg::OP_RUN, $urandom_range(4095), 16'($urandom), rand_base());
         repeat (8) send_op(scpa_pkg::OP_READ_OUTPUT, $urandom_range(n_sum - 1),
                            16'($urandom), rand_base());
      end else begin
         repeat (4) send_op(scpa_pkg::opcode_type'($urandom_range(2)), $urandom_range(4095),
                            16'($urandom), rand_base());
         send_op(scpa_pkg::OP_RUN, $urandom_range(4095), 16'($urandom), rand_base());
         repeat (3) noise_item();
      end
   endtask

   initial begin
      int phase;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      apply_cfg(make_cfg(2, 2, 1, 2, 2, 1, 1, 1));
      send_op(scpa_pkg::OP_LOAD_INPUT, 0, 16'h8000, '0);
      send_op(scpa_pkg::OP_LOAD_INPUT, 1, 16'h7FFF, '0);
      send_op(scpa_pkg::OP_LOAD_INPUT, 2, 16'h8000, '0);
      send_op(scpa_pkg::OP_LOAD_INPUT, 3, 16'h0000, '0);
      send_op(scpa_pkg::OP_LOAD_KERNEL, 0, 16'h8000, '0);
      send_op(scpa_pkg::OP_LOAD_KERNEL, 1, 16'h8000, '0);
      send_op(scpa_pkg::OP_LOAD_KERNEL, 2, 16'h7FFF, '0);
      send_op(scpa_pkg::OP_LOAD_KERNEL, 3, 16'h8000, '0);
      for (int i = 0; i < 9; i++)
         send_op(scpa_pkg::OP_LOAD_OUTPUT, i, '0,
                 (i % 2) ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF);
      send_op(scpa_pkg::OP_RUN, 0, '0, '0);
      send_op(scpa_pkg::OP_READ_OUTPUT, 0, '0, '0);
      send_op(scpa_pkg::OP_READ_OUTPUT, 4, '0, '0);
      send_op(scpa_pkg::OP_LOAD_OUTPUT, 4095, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
      send_op(scpa_pkg::OP_READ_OUTPUT, 4095, '0, '0);
      send_op(scpa_pkg::OP_LOAD_KERNEL, 4095, 16'hFFFF, '0);
      send_op(scpa_pkg::opcode_type'(5), 0, '0, '0);
      send_op(scpa_pkg::opcode_type'(7), 4095, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
      send_op(scpa_pkg::OP_RUN, 0, '0, '0);
      phase = 0;
      while (sent < 1750) begin
         random_phase(phase);
         phase++;
      end
      wait_idle();
      repeat (50) @(negedge clock);
      if (sb.pending.size() != 0) sb.failures++;
      if (sb.failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
